[hw/rtl/quat_rotate_vector_macros.svh]
// ----------------------------------------------------------------------------
// quat_rotate_vector_macros.svh
// Assertion macros shared by the quaternion rotation RTL.
// ----------------------------------------------------------------------------
`ifndef QUAT_ROTATE_VECTOR_MACROS_SVH
`define QUAT_ROTATE_VECTOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle property, sampled on clk, off while arst_n is low.
`define QRV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define QRV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QRV_ASSERT(lbl, prop, msg)
`define QRV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/qrv_pkg.sv]
// ----------------------------------------------------------------------------
// qrv_pkg
// Types, widths and helpers for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qrv_pkg;

	localparam int QW   = 16;          // quaternion part, Q2.14
	localparam int VW   = 16;          // vector component
	localparam int PW   = 2 * QW;      // raw part product, Q4.28
	localparam int EW   = 35;          // matrix entry, 28 fraction bits
	localparam int MW   = EW + VW;     // entry times component
	localparam int SW   = MW + 3;      // row sum plus rounding bias
	localparam int FRAC = 28;
	localparam int NDIM = 3;

	localparam logic signed [EW-1:0] ONE_FIX  = EW'(64'sd1 <<< FRAC);
	localparam logic signed [SW-1:0] HALF_FIX = SW'(64'sd1 <<< (FRAC - 1));
	localparam logic signed [VW-1:0] SAT_MAX  = 16'sh7fff;
	localparam logic signed [VW-1:0] SAT_MIN  = 16'sh8000;
	localparam logic signed [SW-1:0] RND_MAX  = SW'(SAT_MAX);
	localparam logic signed [SW-1:0] RND_MIN  = SW'(SAT_MIN);

	typedef logic signed [VW-1:0] qrv_vec_t;
	typedef logic signed [EW-1:0] qrv_ent_t;
	typedef logic signed [MW-1:0] qrv_mul_t;
	typedef logic signed [SW-1:0] qrv_sum_t;

	typedef struct packed {
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
		logic signed [QW-1:0] quat_w;
		logic signed [VW-1:0] vec_x;
		logic signed [VW-1:0] vec_y;
		logic signed [VW-1:0] vec_z;
		logic                 inverse_dir;
	} qrv_req_t;

	typedef struct packed {
		logic signed [VW-1:0] rot_x;
		logic signed [VW-1:0] rot_y;
		logic signed [VW-1:0] rot_z;
		logic                 clipped;
	} qrv_rsp_t;

	typedef struct packed {
		logic signed [PW-1:0] xx;
		logic signed [PW-1:0] yy;
		logic signed [PW-1:0] zz;
		logic signed [PW-1:0] zx;
		logic signed [PW-1:0] xy;
		logic signed [PW-1:0] yz;
		logic signed [PW-1:0] wx;
		logic signed [PW-1:0] wy;
		logic signed [PW-1:0] wz;
	} qrv_prod_t;

	// Stage control: global advance plus the valid bit of the feeding stage.
	typedef struct packed {
		logic adv;
		logic valid;
	} qrv_ctl_t;

	// Doubled product widened to the matrix entry format.
	function automatic qrv_ent_t dbl(input logic signed [PW-1:0] p);
		qrv_ent_t w;
		w = EW'(p);
		return w <<< 1;
	endfunction

endpackage

[hw/rtl/qrv_req_if.sv]
// ----------------------------------------------------------------------------
// qrv_req_if
// Input channel: quaternion, vector and direction with valid/ready.
// ----------------------------------------------------------------------------
interface qrv_req_if import qrv_pkg::*;;
	logic     valid;
	logic     ready;
	qrv_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/qrv_rsp_if.sv]
// ----------------------------------------------------------------------------
// qrv_rsp_if
// Output channel: rotated vector and clip flag with valid/ready.
// ----------------------------------------------------------------------------
interface qrv_rsp_if import qrv_pkg::*;;
	logic     valid;
	logic     ready;
	qrv_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/qrv_products.sv]
// ----------------------------------------------------------------------------
// qrv_products
// Stage 1: the nine pairwise quaternion part products.
// ----------------------------------------------------------------------------
module qrv_products import qrv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qrv_ctl_t  ctl,
	input  qrv_req_t  req_data,
	output logic      valid_s1,
	output qrv_prod_t prod_s1,
	output qrv_vec_t  vec_s1 [NDIM],
	output logic      inv_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s1.xx <= req_data.quat_x * req_data.quat_x;
			prod_s1.yy <= req_data.quat_y * req_data.quat_y;
			prod_s1.zz <= req_data.quat_z * req_data.quat_z;
			prod_s1.zx <= req_data.quat_z * req_data.quat_x;
			prod_s1.xy <= req_data.quat_x * req_data.quat_y;
			prod_s1.yz <= req_data.quat_y * req_data.quat_z;
			prod_s1.wx <= req_data.quat_w * req_data.quat_x;
			prod_s1.wy <= req_data.quat_w * req_data.quat_y;
			prod_s1.wz <= req_data.quat_w * req_data.quat_z;
			vec_s1[0]  <= req_data.vec_x;
			vec_s1[1]  <= req_data.vec_y;
			vec_s1[2]  <= req_data.vec_z;
			inv_s1     <= req_data.inverse_dir;
		end
	end

endmodule

[hw/rtl/qrv_matrix.sv]
// ----------------------------------------------------------------------------
// qrv_matrix
// Stage 2: build the rotation matrix, transposed for the inverse direction.
// ----------------------------------------------------------------------------
module qrv_matrix import qrv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  qrv_ctl_t  ctl,
	input  qrv_prod_t prod_s1,
	input  qrv_vec_t  vec_s1 [NDIM],
	input  logic      inv_s1,
	output logic      valid_s2,
	output qrv_ent_t  mat_s2 [NDIM][NDIM],
	output qrv_vec_t  vec_s2 [NDIM]
);

	qrv_ent_t m [NDIM][NDIM];

	always_comb begin
		m[0][0] = ONE_FIX - dbl(prod_s1.yy) - dbl(prod_s1.zz);
		m[1][1] = ONE_FIX - dbl(prod_s1.xx) - dbl(prod_s1.zz);
		m[2][2] = ONE_FIX - dbl(prod_s1.xx) - dbl(prod_s1.yy);
		m[0][1] = dbl(prod_s1.xy) - dbl(prod_s1.wz);
		m[1][0] = dbl(prod_s1.xy) + dbl(prod_s1.wz);
		m[0][2] = dbl(prod_s1.zx) + dbl(prod_s1.wy);
		m[2][0] = dbl(prod_s1.zx) - dbl(prod_s1.wy);
		m[1][2] = dbl(prod_s1.yz) - dbl(prod_s1.wx);
		m[2][1] = dbl(prod_s1.yz) + dbl(prod_s1.wx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s2 <= ctl.valid;
		end
	end

	// Swap off-diagonal entries for the inverse rotation.
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int r = 0; r < NDIM; r++) begin
				for (int c = 0; c < NDIM; c++) begin
					mat_s2[r][c] <= inv_s1 ? m[c][r] : m[r][c];
				end
				vec_s2[r] <= vec_s1[r];
			end
		end
	end

endmodule

[hw/rtl/qrv_mac.sv]
// ----------------------------------------------------------------------------
// qrv_mac
// Stages 3 and 4: entry times component, then row sums with rounding bias.
// ----------------------------------------------------------------------------
module qrv_mac import qrv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qrv_ctl_t ctl,
	input  qrv_ent_t mat_s2 [NDIM][NDIM],
	input  qrv_vec_t vec_s2 [NDIM],
	output logic     valid_s4,
	output qrv_sum_t sum_s4 [NDIM]
);

	logic     valid_s3;
	qrv_mul_t mul_s3 [NDIM][NDIM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s3 <= ctl.valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int r = 0; r < NDIM; r++) begin
				for (int c = 0; c < NDIM; c++) begin
					mul_s3[r][c] <= mat_s2[r][c] * vec_s2[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int r = 0; r < NDIM; r++) begin
				sum_s4[r] <= SW'(mul_s3[r][0]) + SW'(mul_s3[r][1])
					+ SW'(mul_s3[r][2]) + HALF_FIX;
			end
		end
	end

endmodule

[hw/rtl/qrv_round.sv]
// ----------------------------------------------------------------------------
// qrv_round
// Stage 5: drop fraction bits, saturate to 16 bits, flag clipping.
// ----------------------------------------------------------------------------
module qrv_round import qrv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qrv_ctl_t ctl,
	input  qrv_sum_t sum_s4 [NDIM],
	output logic     valid_s5,
	output qrv_rsp_t rsp_s5
);

	qrv_sum_t           rnd  [NDIM];
	logic signed [VW-1:0] sat [NDIM];
	logic [NDIM-1:0]    clip;

	always_comb begin
		for (int r = 0; r < NDIM; r++) begin
			rnd[r] = sum_s4[r] >>> FRAC;
			if (rnd[r] > RND_MAX) begin
				sat[r]  = SAT_MAX;
				clip[r] = 1'b1;
			end else if (rnd[r] < RND_MIN) begin
				sat[r]  = SAT_MIN;
				clip[r] = 1'b1;
			end else begin
				sat[r]  = rnd[r][VW-1:0];
				clip[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s5 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rsp_s5.rot_x   <= sat[0];
			rsp_s5.rot_y   <= sat[1];
			rsp_s5.rot_z   <= sat[2];
			rsp_s5.clipped <= |clip;
		end
	end

endmodule

[hw/rtl/quat_rotate_vector.sv]
// ----------------------------------------------------------------------------
// quat_rotate_vector
// Rotate a signed 16-bit vector by a Q2.14 quaternion or by its inverse.
// Five pipeline stages lie between req transfer and rsp valid:
//   part products, matrix build, entry multiply, row sum, round/saturate.
// Throughput: one item per cycle unless rsp is held; a held rsp freezes every stage at once.
// Reset: arst_n clears all stage valid bits; the data path is not reset.
// ----------------------------------------------------------------------------
`include "quat_rotate_vector_macros.svh"

module quat_rotate_vector import qrv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qrv_req_if.sink   req,
	qrv_rsp_if.source rsp
);

	// Advance the whole pipeline whenever the output register is free or its
	// content transfers this cycle; hold every stage otherwise.
	logic adv;
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// Stage controls: the shared advance plus the valid bit of the feeding stage.
	qrv_ctl_t ctl_prod;
	qrv_ctl_t ctl_mat;
	qrv_ctl_t ctl_mac;
	qrv_ctl_t ctl_rnd;

	logic      valid_s1;
	qrv_prod_t prod_s1;
	qrv_vec_t  vec_s1 [NDIM];
	logic      inv_s1;

	logic      valid_s2;
	qrv_ent_t  mat_s2 [NDIM][NDIM];
	qrv_vec_t  vec_s2 [NDIM];

	logic      valid_s4;
	qrv_sum_t  sum_s4 [NDIM];

	logic      valid_s5;
	qrv_rsp_t  rsp_s5;

	assign ctl_prod = '{adv: adv, valid: req.valid};
	assign ctl_mat  = '{adv: adv, valid: valid_s1};
	assign ctl_mac  = '{adv: adv, valid: valid_s2};
	assign ctl_rnd  = '{adv: adv, valid: valid_s4};

	// Stage 1: nine part products; a bubble enters when req is not valid.
	qrv_products u_products (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_prod),
		.req_data (req.data),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.vec_s1   (vec_s1),
		.inv_s1   (inv_s1)
	);

	// Stage 2: rotation matrix, transposed for the inverse direction.
	qrv_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_mat),
		.prod_s1  (prod_s1),
		.vec_s1   (vec_s1),
		.inv_s1   (inv_s1),
		.valid_s2 (valid_s2),
		.mat_s2   (mat_s2),
		.vec_s2   (vec_s2)
	);

	// Stages 3 and 4: nine multiplies, then three exact row sums with rounding bias.
	qrv_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_mac),
		.mat_s2   (mat_s2),
		.vec_s2   (vec_s2),
		.valid_s4 (valid_s4),
		.sum_s4   (sum_s4)
	);

	// Stage 5: round, saturate; this is the output register.
	qrv_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_rnd),
		.sum_s4   (sum_s4),
		.valid_s5 (valid_s5),
		.rsp_s5   (rsp_s5)
	);

	assign rsp.valid = valid_s5;
	assign rsp.data  = rsp_s5;

	// At least one output component sits on a rail.
	logic on_rail;
	assign on_rail = rsp.data.rot_x == SAT_MAX || rsp.data.rot_x == SAT_MIN
		|| rsp.data.rot_y == SAT_MAX || rsp.data.rot_y == SAT_MIN
		|| rsp.data.rot_z == SAT_MAX || rsp.data.rot_z == SAT_MIN;

	// A finished row sum reaches the output on the next advance.
	`QRV_ASSERT_NEXT(a_s4_to_out, adv && valid_s4, rsp.valid, "row sum lost before output")

	// A stalled row sum stays put until the output frees up.
	`QRV_ASSERT_NEXT(a_s4_hold, !adv && valid_s4, valid_s4 && $stable(sum_s4[0]), "stalled sum moved")

	// A held result blocks new input transfers.
	`QRV_ASSERT(a_stall_blocks_in, !(rsp.valid && !rsp.ready && req.ready), "input taken during stall")

	// The clip flag implies at least one component sits on a rail.
	`QRV_ASSERT(a_clip_rail, !(rsp.valid && rsp.data.clipped) || on_rail, "clip without a rail value")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quat_rotate_vector. Drives quaternion/vector items
// on the request channel, predicts each rotation in 64-bit integer math and
// compares every response field in order. Both channels idle in random
// bursts; one long response hold backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench import qrv_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ROT_SHIFT = 28;
	localparam longint ROT_UNIT  = 64'sd1 <<< ROT_SHIFT;
	localparam longint ROT_HALF  = 64'sd1 <<< (ROT_SHIFT - 1);
	localparam int     LONG_HOLD_CYCLES = 150;
	localparam int     FILL_ITEMS       = 48;
	localparam int     RANDOM_ITEMS     = 1150;
	localparam int     CALM_ITEMS       = 200;
	localparam int     SETTLE_CYCLES    = 12;

	// Holds the rotations still owed by the block and checks them in order.
	class rotation_scoreboard;
		qrv_rsp_t pending_rotations[$];
		int       fail_count;

		function new();
			fail_count = 0;
		endfunction

		// Rotate by R or its transpose; round half up, saturate to 16 bits.
		function qrv_rsp_t rotate_predict(qrv_req_t r);
			longint   qx, qy, qz, qw;
			longint   xx, yy, zz, zx, xy, yz, wx, wy, wz;
			longint   m[3][3];
			longint   v[3];
			longint   acc, rnd;
			qrv_vec_t comp[3];
			logic     clip;
			qrv_rsp_t res;
			qx = $signed(r.quat_x);
			qy = $signed(r.quat_y);
			qz = $signed(r.quat_z);
			qw = $signed(r.quat_w);
			v[0] = $signed(r.vec_x);
			v[1] = $signed(r.vec_y);
			v[2] = $signed(r.vec_z);
			xx = 2 * qx * qx;
			yy = 2 * qy * qy;
			zz = 2 * qz * qz;
			zx = 2 * qz * qx;
			xy = 2 * qx * qy;
			yz = 2 * qy * qz;
			wx = 2 * qw * qx;
			wy = 2 * qw * qy;
			wz = 2 * qw * qz;
			m[0][0] = ROT_UNIT - yy - zz;
			m[0][1] = xy - wz;
			m[0][2] = zx + wy;
			m[1][0] = xy + wz;
			m[1][1] = ROT_UNIT - xx - zz;
			m[1][2] = yz - wx;
			m[2][0] = zx - wy;
			m[2][1] = yz + wx;
			m[2][2] = ROT_UNIT - xx - yy;
			clip = 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += (r.inverse_dir ? m[j][i] : m[i][j]) * v[j];
				rnd = (acc + ROT_HALF) >>> ROT_SHIFT;
				if (rnd > 32767) begin
					rnd = 32767;
					clip = 1'b1;
				end else if (rnd < -32768) begin
					rnd = -32768;
					clip = 1'b1;
				end
				comp[i] = 16'(rnd);
			end
			res.rot_x = comp[0];
			res.rot_y = comp[1];
			res.rot_z = comp[2];
			res.clipped = clip;
			return res;
		endfunction

		function void note_request(qrv_req_t r);
			pending_rotations.push_back(rotate_predict(r));
		endfunction

		function void check_result(qrv_rsp_t got);
			qrv_rsp_t want;
			if (pending_rotations.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%t: result with nothing outstanding: %0d %0d %0d clip=%0b",
						$realtime, got.rot_x, got.rot_y, got.rot_z, got.clipped);
				return;
			end
			want = pending_rotations.pop_front();
			if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
				got.rot_z !== want.rot_z || got.clipped !== want.clipped) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%t: mismatch: exp %0d %0d %0d clip=%0b, got %0d %0d %0d clip=%0b",
						$realtime, want.rot_x, want.rot_y, want.rot_z, want.clipped,
						got.rot_x, got.rot_y, got.rot_z, got.clipped);
			end
		endfunction

		function int pending();
			return pending_rotations.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idle_on;      // random idle bursts on both channels
	bit   fill_phase;   // start of the long response hold
	bit   hold_sink;    // response side held off, changed on falling edges

	rotation_scoreboard sb;

	qrv_req_if req_ch();
	qrv_rsp_if rsp_ch();

	quat_rotate_vector DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up after a generous fixed time; a clean run needs well under a tenth.
	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic qrv_req_t make_req(int qx, int qy, int qz, int qw,
		int vx, int vy, int vz, int dir);
		qrv_req_t r;
		r.quat_x = 16'(qx);
		r.quat_y = 16'(qy);
		r.quat_z = 16'(qz);
		r.quat_w = 16'(qw);
		r.vec_x = 16'(vx);
		r.vec_y = 16'(vy);
		r.vec_z = 16'(vz);
		r.inverse_dir = 1'(dir);
		return r;
	endfunction

	// Pick a component at or near the ends of the 16-bit range, or near zero.
	function automatic int edge_value();
		case ($urandom_range(0, 6))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	function automatic real unit_rand();
		return (real'($urandom_range(0, 65535)) - 32767.5) / 32767.5;
	endfunction

	// Draw one random item: mostly unit quaternions with full-range vectors,
	// plus raw bit patterns (drives saturation), edge vectors and axis turns.
	function automatic qrv_req_t random_item();
		real      a, b, c, d, norm;
		int       vx, vy, vz, k, s;
		qrv_req_t r;
		vx = $signed(16'($urandom));
		vy = $signed(16'($urandom));
		vz = $signed(16'($urandom));
		a = unit_rand();
		b = unit_rand();
		c = unit_rand();
		d = unit_rand();
		norm = $sqrt(a * a + b * b + c * c + d * d);
		if (norm < 1.0e-3) begin
			a = 0.0;
			b = 0.0;
			c = 0.0;
			d = 1.0;
			norm = 1.0;
		end
		r = make_req($rtoi(a / norm * 16384.0), $rtoi(b / norm * 16384.0),
			$rtoi(c / norm * 16384.0), $rtoi(d / norm * 16384.0), vx, vy, vz,
			$urandom_range(0, 1));
		case ($urandom_range(0, 9))
			6, 7: begin
				r.quat_x = 16'($urandom);
				r.quat_y = 16'($urandom);
				r.quat_z = 16'($urandom);
				r.quat_w = 16'($urandom);
			end
			8: begin
				r.vec_x = 16'(edge_value());
				r.vec_y = 16'(edge_value());
				r.vec_z = 16'(edge_value());
			end
			9: begin
				// quarter or half turn about one axis, either sign
				k = $urandom_range(0, 2);
				s = $urandom_range(0, 1) ? 11585 : -11585;
				r = make_req(0, 0, 0, 11585, vx, vy, vz, $urandom_range(0, 1));
				if ($urandom_range(0, 1)) begin
					r.quat_w = 16'd0;
					s = (s > 0) ? 16384 : -16384;
				end
				case (k)
					0: r.quat_x = 16'(s);
					1: r.quat_y = 16'(s);
					default: r.quat_z = 16'(s);
				endcase
			end
			default: begin
				// nudge off unit length now and then
				if ($urandom_range(0, 3) == 0)
					r.quat_w = r.quat_w + 16'($urandom_range(0, 6)) - 16'd3;
			end
		endcase
		return r;
	endfunction

	// Offer one item and hold it until the transfer; note it at the transfer edge.
	task automatic send_item(input qrv_req_t item);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(item);
	endtask

	// Drop valid and wait until every predicted rotation has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Response side: random stall bursts while idling is on, plus the long hold.
	initial begin : result_sink
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.data);
			if (idle_on && stall_left == 0 && run_left == 0) begin
				if ($urandom_range(0, 9) < 3)
					stall_left = $urandom_range(1, 12);
				else
					run_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (run_left > 0)
					run_left--;
				rsp_ch.ready <= !hold_sink && arst_n;
			end
		end
	end

	// Hold the response side off long enough that the pipeline fills and
	// stalls its input; count the hold here, apart from the random stalls.
	initial begin : long_hold
		hold_sink = 1'b0;
		wait (fill_phase);
		@(negedge clk);
		hold_sink = 1'b1;
		repeat (LONG_HOLD_CYCLES) @(negedge clk);
		hold_sink = 1'b0;
	end

	initial begin : stimulus
		qrv_req_t directed[$];
		sb = new();
		idle_on = 1'b0;
		fill_phase = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero quaternion collapses the matrix to identity
		directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0));
		// identity and its negative with extreme vector parts
		directed.push_back(make_req(0, 0, 0, 16384, 32767, -32768, 1, 0));
		directed.push_back(make_req(0, 0, 0, 16384, 32767, -32768, 1, 1));
		directed.push_back(make_req(0, 0, 0, -16384, -1, 12345, -32768, 0));
		// quarter turns about z and y, both directions
		directed.push_back(make_req(0, 0, 11585, 11585, 1000, -2000, 3000, 0));
		directed.push_back(make_req(0, 0, 11585, 11585, 1000, -2000, 3000, 1));
		directed.push_back(make_req(0, 11585, 0, 11585, 32767, 0, -32768, 0));
		directed.push_back(make_req(0, 11585, 0, 11585, 32767, 0, -32768, 1));
		// half turn about x
		directed.push_back(make_req(16384, 0, 0, 0, 100, 200, 300, 1));
		// exact half on the diagonal: ties round up, so -0.5 goes to zero
		directed.push_back(make_req(8192, 0, 0, 0, 0, 1, 0, 0));
		directed.push_back(make_req(8192, 0, 0, 0, 0, -1, 0, 0));
		directed.push_back(make_req(8192, 0, 0, 0, 0, 3, -3, 1));
		// full-scale parts: saturation both ways
		directed.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
		directed.push_back(make_req(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, 1));
		directed.push_back(make_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 0));
		directed.push_back(make_req(32767, -32768, 32767, -32768, -32768, 32767, -32768, 1));
		// non-unit quaternion used as is
		directed.push_back(make_req(16384, 16384, 16384, 16384, 500, -500, 250, 0));
		directed.push_back(make_req(0, 0, 0, 1, -1, -1, -1, 1));
		directed.push_back(make_req(1, 0, 0, 16384, 32767, 32767, 32767, 0));
		// alternating bit patterns
		directed.push_back(make_req(21845, -21846, 21845, -21846, -21846, 21845, -21846, 1));
		directed.push_back(make_req(-21846, 21845, -21846, 21845, 21845, -21846, 21845, 0));

		idle_on = 1'b1;
		foreach (directed[i])
			send_item(directed[i]);
		// pause the sender until the block has emptied
		drain();

		// back-to-back items against a held response side
		idle_on = 1'b0;
		fill_phase = 1'b1;
		repeat (FILL_ITEMS)
			send_item(random_item());

		idle_on = 1'b1;
		repeat (RANDOM_ITEMS)
			send_item(random_item());

		// run the tail at full rate
		idle_on = 1'b0;
		repeat (CALM_ITEMS)
			send_item(random_item());

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
